// ----- rtl/zafu_pkg.sv -----
// Shared types and constants for the Z80-style ALU flag unit.
// No dependencies; imported by zafu_alu, the top level and zafu_checker.
package zafu_pkg;

  // Operation select codes
  typedef enum logic [3:0] {
    MODE_INC8  = 4'd0,
    MODE_DEC8  = 4'd1,
    MODE_CPL   = 4'd2,
    MODE_DAA   = 4'd3,
    MODE_RL    = 4'd4,
    MODE_RLC   = 4'd5,
    MODE_RR    = 4'd6,
    MODE_RRC   = 4'd7,
    MODE_SCF   = 4'd8,
    MODE_ADD16 = 4'd9,
    MODE_INC16 = 4'd10,
    MODE_DEC16 = 4'd11
  } mode_t;

  // Flag register bit positions
  localparam int unsigned FL_C  = 0;
  localparam int unsigned FL_N  = 1;
  localparam int unsigned FL_PV = 2;
  localparam int unsigned FL_3  = 3;
  localparam int unsigned FL_H  = 4;
  localparam int unsigned FL_5  = 5;
  localparam int unsigned FL_Z  = 6;
  localparam int unsigned FL_S  = 7;

  // BCD adjust constants
  localparam logic [9:0] DAA_LO_ADJ  = 10'h006;
  localparam logic [9:0] DAA_HI_ADJ  = 10'h060;
  localparam logic [9:0] DAA_HI_LIM  = 10'h09F;
  localparam logic [3:0] DAA_DIG_MAX = 4'd9;

  // Packed widths of one transaction
  localparam int unsigned IN_BITS  = 44;
  localparam int unsigned OUT_BITS = 24;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 24;

  // Input item, last field in the lowest bits
  typedef struct packed {
    logic [7:0]  flags_in;
    logic [15:0] operand_b;
    logic [15:0] operand_a;
    logic [3:0]  mode;
  } in_item_t;

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic [7:0]  flags_out;
    logic [15:0] result;
  } out_item_t;

endpackage

// ----- rtl/zafu_stage.sv -----
// Valid/ready register stage holding one transaction.
// Generic; no package dependency.
module zafu_stage #(
  parameter int unsigned Width = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [Width-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [Width-1:0] out_data
);

  logic             valid_r;
  logic             valid_nxt;
  logic [Width-1:0] data_r;
  logic             load;

  // Take a new transaction when empty or when the held one leaves
  assign in_ready  = !valid_r || out_ready;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- rtl/zafu_alu.sv -----
// Combinational ALU datapath: result and Z80-layout flags for one item.
// Depends on zafu_pkg for item types, mode codes and flag positions.
module zafu_alu
  import zafu_pkg::*;
(
  input  in_item_t  item,
  output out_item_t res
);

  always_comb begin
    logic [7:0]  a8;
    logic [7:0]  r8;
    logic [7:0]  f;
    logic [9:0]  t;
    logic [16:0] sum;
    logic [12:0] sum_lo;
    logic [15:0] r;

    a8     = item.operand_a[7:0];
    f      = item.flags_in;
    r      = item.operand_a;
    r8     = 8'h00;
    t      = {2'b00, a8};
    sum    = {1'b0, item.operand_a} + {1'b0, item.operand_b};
    sum_lo = {1'b0, item.operand_a[11:0]} + {1'b0, item.operand_b[11:0]};

    unique case (item.mode)
      MODE_INC8, MODE_DEC8: begin
        if (item.mode == MODE_INC8) begin
          r8       = a8 + 8'd1;
          f[FL_H]  = (r8[3:0] == 4'h0);
          f[FL_PV] = (r8 == 8'h80);
          f[FL_N]  = 1'b0;
        end else begin
          r8       = a8 - 8'd1;
          f[FL_H]  = (r8[3:0] == 4'hF);
          f[FL_PV] = (r8 == 8'h7F);
          f[FL_N]  = 1'b1;
        end
        f[FL_S] = r8[7];
        f[FL_Z] = (r8 == 8'h00);
        f[FL_5] = r8[5];
        f[FL_3] = r8[3];
        r       = {8'h00, r8};
      end
      MODE_CPL: begin
        r8      = ~a8;
        f[FL_5] = r8[5];
        f[FL_3] = r8[3];
        f[FL_H] = 1'b1;
        f[FL_N] = 1'b1;
        r       = {8'h00, r8};
      end
      MODE_DAA: begin
        // Worked in 10-bit two's complement; bit 8 yields the carry
        if (!f[FL_N]) begin
          if (f[FL_H] || (t[3:0] > DAA_DIG_MAX)) begin
            t = t + DAA_LO_ADJ;
          end
          if (f[FL_C] || (t > DAA_HI_LIM)) begin
            t = t + DAA_HI_ADJ;
          end
        end else begin
          if (f[FL_H]) begin
            t = t - DAA_LO_ADJ;
            if (!f[FL_C]) begin
              t = {2'b00, t[7:0]};
            end
          end
          if (f[FL_C]) begin
            t = t - DAA_HI_ADJ;
          end
        end
        f[FL_H] = 1'b0;
        if (t[8]) begin
          f[FL_C] = 1'b1;
        end
        r8      = t[7:0];
        f[FL_Z] = (r8 == 8'h00);
        r       = {8'h00, r8};
      end
      MODE_RL, MODE_RLC, MODE_RR, MODE_RRC: begin
        unique case (item.mode)
          MODE_RL:  r8 = {a8[6:0], f[FL_C]};
          MODE_RLC: r8 = {a8[6:0], a8[7]};
          MODE_RR:  r8 = {f[FL_C], a8[7:1]};
          default:  r8 = {a8[0], a8[7:1]};
        endcase
        f[FL_5] = r8[5];
        f[FL_3] = r8[3];
        f[FL_H] = 1'b0;
        f[FL_N] = 1'b0;
        f[FL_C] = (item.mode == MODE_RL || item.mode == MODE_RLC) ? a8[7] : a8[0];
        r       = {8'h00, r8};
      end
      MODE_SCF: begin
        f[FL_5] = a8[5];
        f[FL_3] = a8[3];
        f[FL_H] = 1'b0;
        f[FL_N] = 1'b0;
        f[FL_C] = 1'b1;
      end
      MODE_ADD16: begin
        r       = sum[15:0];
        f[FL_H] = sum_lo[12];
        f[FL_S] = r[15];
        f[FL_Z] = (r == 16'h0000);
        f[FL_5] = r[13];
        f[FL_3] = r[11];
        f[FL_N] = 1'b0;
        f[FL_C] = sum[16];
      end
      MODE_INC16: r = item.operand_a + 16'd1;
      MODE_DEC16: r = item.operand_a - 16'd1;
      // Unassigned codes pass operand and flags through
      default:    r = item.operand_a;
    endcase

    res.result    = r;
    res.flags_out = f;
  end

endmodule

// ----- rtl/z80_alu_flag_unit_core.sv -----
// Top level of the Z80-style ALU flag unit: input register, ALU, result register.
// Depends on zafu_pkg, zafu_stage and zafu_alu.
//
// One operation per transaction, one transaction accepted per clock when the
// result side keeps up. From input acceptance to out_tvalid an item is held in
// the input register, the ALU evaluates between the input and result
// registers, then the result register presents the outcome.
// Both registers are valid/ready stages, so a stalled result still lets one
// more item enter; in_tready is combinational from out_tready through the two
// stages. Unused mode codes return operand_a and flags_in unchanged.
module z80_alu_flag_unit_core
  import zafu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [3:0] mode, [19:4] operand_a, [35:20] operand_b, [43:36] flags_in, [47:44] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] result, [23:16] flags_out
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic      s1_valid;
  logic      s1_ready;
  in_item_t  s1_item;
  out_item_t alu_res;

  // Input register
  zafu_stage #(.Width(IN_BITS)) u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata[IN_BITS-1:0]),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_item)
  );

  // Datapath
  zafu_alu u_alu (
    .item (s1_item),
    .res  (alu_res)
  );

  // Result register
  zafu_stage #(.Width(OUT_BITS)) u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (alu_res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

// ----- rtl/zafu_checker.sv -----
// Port-level checks for z80_alu_flag_unit_core, attached by bind.
// Depends on zafu_pkg for the stream widths.
module zafu_checker
  import zafu_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] inflight_r;
  logic [1:0] inflight_nxt;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // Transactions accepted but not yet delivered
  always_comb begin
    inflight_nxt = inflight_r;
    if (in_acc && !out_acc) begin
      inflight_nxt = inflight_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      inflight_nxt = inflight_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 2'd0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  // Never more than the two register stages hold
  a_inflight_max: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r != 2'd3)
    else $error("more transactions in flight than stages");

  // No result without a pending transaction
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r == 2'd0 |-> !out_tvalid)
    else $error("result presented with nothing in flight");

  // Empty pipe delivers once the item has passed the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && inflight_r == 2'd0) |=> ##1 out_tvalid)
    else $error("result late on an empty pipe");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind z80_alu_flag_unit_core zafu_checker u_zafu_checker (.*);

// ----- sim/tb.sv -----
// Self-checking bench for z80_alu_flag_unit_core: directed flag vectors, then random traffic.
// Depends on zafu_pkg and the RTL top level; results are checked against typed values or a local ALU model.
`timescale 1ns / 1ps

module tb;
  import zafu_pkg::*;

  localparam int          NUM_VECTORS     = 26;
  localparam int          RANDOM_ITEMS    = 1850;
  localparam int          HOLD_CYCLES     = 150;
  localparam int          WATCHDOG_CYCLES = 2000;
  localparam logic [3:0]  MODE_SPARE_LO   = 4'd12;
  localparam logic [3:0]  MODE_SPARE_HI   = 4'd15;

  // One directed vector; r_want/f_want only meaningful when typed is set
  typedef struct packed {
    logic [3:0]  mode;
    logic [15:0] a;
    logic [15:0] b;
    logic [7:0]  f;
    logic        typed;
    logic [15:0] r_want;
    logic [7:0]  f_want;
  } vector_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Sideband that travels with the driven item: hand-typed expectation
  logic      drv_typed;
  out_item_t drv_typed_res;

  // Traffic shaping controls
  logic steady;
  logic hold_go;
  logic hold_done;
  int   stall_left;

  out_item_t   alu_q[$];
  int          err_count = 0;
  int          in_count = 0;
  int          out_count = 0;
  int          quiet_cycles = 0;
  logic [15:0] mode_seen = '0;

  vector_t vectors [NUM_VECTORS] = '{
    '{MODE_INC8,     16'h00FF, 16'h0000, 8'h00, 1'b1, 16'h0000, 8'h50},
    '{MODE_INC8,     16'h007F, 16'hFFFF, 8'hFF, 1'b1, 16'h0080, 8'h95},
    '{MODE_INC8,     16'h120F, 16'h0000, 8'h00, 1'b0, 16'h0000, 8'h00},
    '{MODE_DEC8,     16'h0000, 16'h0000, 8'h00, 1'b1, 16'h00FF, 8'hBA},
    '{MODE_DEC8,     16'hFF80, 16'h0000, 8'h01, 1'b1, 16'h007F, 8'h3F},
    '{MODE_DEC8,     16'h0010, 16'h0000, 8'h00, 1'b0, 16'h0000, 8'h00},
    '{MODE_CPL,      16'h0000, 16'h0000, 8'h00, 1'b1, 16'h00FF, 8'h3A},
    '{MODE_CPL,      16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 16'h0000, 8'hD7},
    '{MODE_DAA,      16'h0000, 16'h0000, 8'h00, 1'b1, 16'h0000, 8'h40},
    '{MODE_DAA,      16'h009A, 16'h0000, 8'h00, 1'b0, 16'h0000, 8'h00},
    '{MODE_DAA,      16'h0099, 16'h0000, 8'h01, 1'b0, 16'h0000, 8'h00},
    '{MODE_DAA,      16'h0000, 16'h0000, 8'h12, 1'b0, 16'h0000, 8'h00},
    '{MODE_DAA,      16'h0005, 16'h0000, 8'h13, 1'b0, 16'h0000, 8'h00},
    '{MODE_DAA,      16'h00FF, 16'h0000, 8'h10, 1'b0, 16'h0000, 8'h00},
    '{MODE_RL,       16'h0080, 16'h0000, 8'h00, 1'b1, 16'h0000, 8'h01},
    '{MODE_RLC,      16'h0081, 16'h0000, 8'hFE, 1'b0, 16'h0000, 8'h00},
    '{MODE_RR,       16'h0001, 16'h0000, 8'h01, 1'b1, 16'h0080, 8'h01},
    '{MODE_RRC,      16'h00FE, 16'h0000, 8'hFF, 1'b0, 16'h0000, 8'h00},
    '{MODE_SCF,      16'hFFFF, 16'h0000, 8'h00, 1'b1, 16'hFFFF, 8'h29},
    '{MODE_ADD16,    16'hFFFF, 16'h0001, 8'h00, 1'b1, 16'h0000, 8'h51},
    '{MODE_ADD16,    16'h0FFF, 16'h0001, 8'hFF, 1'b0, 16'h0000, 8'h00},
    '{MODE_ADD16,    16'h7FFF, 16'h7FFF, 8'h00, 1'b0, 16'h0000, 8'h00},
    '{MODE_INC16,    16'hFFFF, 16'h0000, 8'hA5, 1'b1, 16'h0000, 8'hA5},
    '{MODE_DEC16,    16'h0000, 16'h0000, 8'h5A, 1'b1, 16'hFFFF, 8'h5A},
    '{MODE_SPARE_LO, 16'h1234, 16'hFFFF, 8'h3C, 1'b1, 16'h1234, 8'h3C},
    '{MODE_SPARE_HI, 16'hFFFF, 16'h0000, 8'hFF, 1'b1, 16'hFFFF, 8'hFF}
  };

  z80_alu_flag_unit_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // ALU behavior: result and new flags for one operation
  function automatic out_item_t alu_outcome(input in_item_t it);
    out_item_t  res;
    logic [7:0] a8;
    logic [7:0] r8;
    logic [7:0] f;
    logic [16:0] sum;
    logic [12:0] low_sum;
    int         t;
    a8 = it.operand_a[7:0];
    f  = it.flags_in;
    r8 = 8'h00;
    res.result = it.operand_a;
    case (it.mode)
      MODE_INC8, MODE_DEC8: begin
        if (it.mode == MODE_INC8) begin
          r8 = a8 + 8'd1;
          f[FL_H]  = (r8[3:0] == 4'h0);
          f[FL_PV] = (r8 == 8'h80);
          f[FL_N]  = 1'b0;
        end else begin
          r8 = a8 - 8'd1;
          f[FL_H]  = (r8[3:0] == 4'hF);
          f[FL_PV] = (r8 == 8'h7F);
          f[FL_N]  = 1'b1;
        end
        f[FL_S] = r8[7];
        f[FL_Z] = (r8 == 8'h00);
        f[FL_5] = r8[5];
        f[FL_3] = r8[3];
        res.result = {8'h00, r8};
      end
      MODE_CPL: begin
        r8 = ~a8;
        f[FL_5] = r8[5];
        f[FL_3] = r8[3];
        f[FL_H] = 1'b1;
        f[FL_N] = 1'b1;
        res.result = {8'h00, r8};
      end
      MODE_DAA: begin
        // decimal adjust in wide two's complement; only H, C and Z move
        t = int'(a8);
        if (!f[FL_N]) begin
          if (f[FL_H] || a8[3:0] > 4'd9) t += 6;
          if (f[FL_C] || t > 'h9F) t += 'h60;
        end else begin
          if (f[FL_H]) begin
            t -= 6;
            if (!f[FL_C]) t &= 'hFF;
          end
          if (f[FL_C]) t -= 'h60;
        end
        f[FL_H] = 1'b0;
        if (t[8]) f[FL_C] = 1'b1;
        r8 = t[7:0];
        f[FL_Z] = (r8 == 8'h00);
        res.result = {8'h00, r8};
      end
      MODE_RL, MODE_RLC, MODE_RR, MODE_RRC: begin
        case (it.mode)
          MODE_RL:  r8 = {a8[6:0], f[FL_C]};
          MODE_RLC: r8 = {a8[6:0], a8[7]};
          MODE_RR:  r8 = {f[FL_C], a8[7:1]};
          default:  r8 = {a8[0], a8[7:1]};
        endcase
        f[FL_C] = (it.mode == MODE_RL || it.mode == MODE_RLC) ? a8[7] : a8[0];
        f[FL_5] = r8[5];
        f[FL_3] = r8[3];
        f[FL_H] = 1'b0;
        f[FL_N] = 1'b0;
        res.result = {8'h00, r8};
      end
      MODE_SCF: begin
        f[FL_5] = a8[5];
        f[FL_3] = a8[3];
        f[FL_H] = 1'b0;
        f[FL_N] = 1'b0;
        f[FL_C] = 1'b1;
      end
      MODE_ADD16: begin
        sum     = {1'b0, it.operand_a} + {1'b0, it.operand_b};
        low_sum = {1'b0, it.operand_a[11:0]} + {1'b0, it.operand_b[11:0]};
        res.result = sum[15:0];
        f[FL_H] = low_sum[12];
        f[FL_S] = sum[15];
        f[FL_Z] = (sum[15:0] == 16'h0000);
        f[FL_5] = sum[13];
        f[FL_3] = sum[11];
        f[FL_N] = 1'b0;
        f[FL_C] = sum[16];
      end
      MODE_INC16: res.result = it.operand_a + 16'd1;
      MODE_DEC16: res.result = it.operand_a - 16'd1;
      default: ;
    endcase
    res.flags_out = f;
    return res;
  endfunction

  // Mostly zero, sometimes short, rarely a long stretch
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Operand biased toward byte and word boundaries
  function automatic logic [15:0] rand_operand();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return {8'($urandom), 8'h7F + 8'($urandom_range(0, 1))};
      3:       return {4'($urandom), 12'hFFF};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.mode      = ($urandom_range(0, 99) < 92) ? 4'($urandom_range(0, 11))
                                                : 4'($urandom_range(12, 15));
    it.operand_a = rand_operand();
    it.operand_b = rand_operand();
    it.flags_in  = 8'($urandom);
    // DAA usually follows a decimal add or subtract, so favor BCD-looking bytes
    if (it.mode == MODE_DAA && $urandom_range(0, 1) == 1)
      it.operand_a[7:0] = {4'($urandom_range(0, 10)), 4'($urandom_range(0, 10))};
    return it;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    $display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Offer one transaction and wait for it to be taken, then idle for gap cycles
  task automatic send_item(input in_item_t it, input logic typed, input out_item_t want,
                           input int gap);
    in_tdata      <= {{(IN_TDATA_W - IN_BITS){1'b0}}, it};
    drv_typed     <= typed;
    drv_typed_res <= want;
    in_tvalid     <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side backpressure, including one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
      hold_done  <= 1'b0;
    end else if (hold_go && !hold_done) begin
      out_tready <= 1'b0;
      stall_left <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (steady || $urandom_range(0, 99) >= 25) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      stall_left <= idle_len();
    end
  end

  // Scoreboard: queue expectations on input transactions, check on output ones
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    in_item_t  taken;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        taken = in_item_t'(in_tdata[IN_BITS-1:0]);
        alu_q.push_back(drv_typed ? drv_typed_res : alu_outcome(taken));
        mode_seen[taken.mode] = 1'b1;
        in_count++;
      end
      if (out_tvalid && out_tready) begin
        got = out_item_t'(out_tdata);
        out_count++;
        if (alu_q.size() == 0) begin
          report_mismatch("result with nothing pending", int'(got), 0);
        end else begin
          want = alu_q.pop_front();
          if (got.result !== want.result)
            report_mismatch("result", int'(got.result), int'(want.result));
          if (got.flags_out !== want.flags_out)
            report_mismatch("flags_out", int'(got.flags_out), int'(want.flags_out));
        end
      end
      // watchdog on cycles where neither side moves a transaction
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_CYCLES);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Stimulus: reset, directed vectors, then random traffic in phases
  initial begin
    in_item_t  it;
    out_item_t want;
    int        gap;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    drv_typed     = 1'b0;
    drv_typed_res = '0;
    steady        = 1'b0;
    hold_go       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[k]) begin
      it.mode          = vectors[k].mode;
      it.operand_a     = vectors[k].a;
      it.operand_b     = vectors[k].b;
      it.flags_in      = vectors[k].f;
      want.result      = vectors[k].r_want;
      want.flags_out   = vectors[k].f_want;
      send_item(it, vectors[k].typed, want, idle_len());
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // long receiver hold-off while the sender keeps pushing
      if (i == 400) hold_go <= 1'b1;
      // sender pause until the pipe has drained
      if (i == 1000) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (alu_q.size() != 0);
      end
      steady <= (i >= 1200 && i < 1400);
      gap = ((i >= 400 && i < 470) || (i >= 1200 && i < 1400)) ? 0 : idle_len();
      send_item(rand_item(), 1'b0, '0, gap);
    end

    // drain and let the pipe settle
    in_tvalid <= 1'b0;
    do @(posedge clk); while (alu_q.size() != 0);
    repeat (6) @(posedge clk);
    if (alu_q.size() != 0)
      report_mismatch("results never delivered", 0, alu_q.size());

    $display("Run sent %0d and received %0d transactions (%0d directed), %0d of 16 modes seen.",
             in_count, out_count, NUM_VECTORS, $countones(mode_seen));
    $display("Included a %0d-cycle result stall with input backing up and a full drain pause.",
             HOLD_CYCLES);
    if (err_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- z80_alu_flag_unit_core.f -----
rtl/zafu_pkg.sv
rtl/zafu_stage.sv
rtl/zafu_alu.sv
rtl/z80_alu_flag_unit_core.sv
rtl/zafu_checker.sv
sim/tb.sv
